>>> design/grid_feature_bucketing_filter_defines.svh
// Assertion macros for the grid bucketing filter checker.
`ifndef GRID_FEATURE_BUCKETING_FILTER_DEFINES_SVH
`define GRID_FEATURE_BUCKETING_FILTER_DEFINES_SVH
// Implication checked on every edge outside reset.
`define GFB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gfb check failed");
// Next-cycle implication checked outside reset.
`define GFB_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gfb check failed");
`endif

>>> design/gfb_pkg.sv
// Shared types and constants of the grid bucketing filter.
package gfb_pkg;
    // Q12.4 coordinates: whole-pixel sizes are scaled by 2^COORD_FRAC_BITS
    localparam int COORD_FRAC_BITS = 4;

    localparam logic [2:0] OUT_STORED   = 3'd0;
    localparam logic [2:0] OUT_OUTSIDE  = 3'd1;
    localparam logic [2:0] OUT_EDGE     = 3'd2;
    localparam logic [2:0] OUT_FULL     = 3'd3;
    localparam logic [2:0] OUT_CLOSE    = 3'd4;
    localparam logic [2:0] OUT_OVERFLOW = 3'd5;

    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_BLOCK_W  = 3'd2;
    localparam logic [2:0] REG_BLOCK_H  = 3'd3;
    localparam logic [2:0] REG_COLS     = 3'd4;
    localparam logic [2:0] REG_ROWS     = 3'd5;
    localparam logic [2:0] REG_MIN_DIST = 3'd6;
    localparam logic [2:0] REG_MAX_PB   = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV, S_INDEX, S_CNT, S_EDGE, S_WALK, S_WAIT, S_CMP, S_STORE, S_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] offset_x;
        logic [15:0] offset_y;
        logic [11:0] block_width;
        logic [11:0] block_height;
        logic [6:0]  grid_cols;
        logic [6:0]  grid_rows;
        logic [7:0]  min_distance;
        logic [9:0]  max_per_block;
    } t_cfg;
endpackage

>>> design/grid_feature_bucketing_filter.sv
// Flow, input transaction to result valid: a point outside the grid skips the column/row
// divider. Every other point goes through it; then an out-of-range block index is reported,
// a reference point is stored (or overflows), and a candidate gets an edge/fullness check
// and then a walk over the n points its block holds (read, square, compare per stored point).
// One item is in flight at a time; the next is taken in the cycle after the result transaction.
// Reset (synchronous, active low) restores register defaults and marks every block count empty.
module grid_feature_bucketing_filter import gfb_pkg::*; #(
    parameter int MAX_BLOCKS      = 64,
    parameter int SLOTS_PER_BLOCK = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // point_x, point_y
    input  logic [1:0]  s_axis_tuser,   // kind, clear_grid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // accepted, block_index, outcome, zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW  = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
    localparam int CW  = $clog2(SLOTS_PER_BLOCK + 1);
    localparam int AW  = BW + SW;
    localparam int PD  = MAX_BLOCKS << SW;
    localparam int QW  = 12 + COORD_FRAC_BITS;
    localparam int MQW = 8 + COORD_FRAC_BITS;

    t_cfg w_cfg;
    t_state r_state, n_state;

    logic        r_kind;
    logic [15:0] r_px, r_py;
    logic [15:0] r_dx, r_dy;
    logic [15:0] r_col, r_row;
    logic [BW-1:0] r_idx;
    logic [13:0] r_idx_full;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [31:0] r_sqx, r_sqy;
    logic [31:0] r_lim;
    logic        r_outside;

    logic          r_ovalid;
    logic          r_oacc;
    logic [5:0]    r_oidx;
    logic [2:0]    r_ocode;
    logic [2:0]    n_ocode;
    logic          n_done;

    logic [CW-1:0] r_count_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_cvalid;
    logic [31:0]   r_pmem [PD];
    logic [31:0]   r_rd;

    logic        w_div_done;
    logic [15:0] w_qx, w_qy;
    logic [QW-1:0] w_bwq, w_bhq;
    logic [MQW-1:0] w_mdq;
    logic [23:0] w_xr, w_yb;
    logic [31:0] w_xl, w_yt;
    logic [15:0] w_ex, w_ey;
    logic [32:0] w_dist;

    gfb_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_cfg(w_cfg)
    );

    assign w_bwq = {w_cfg.block_width, {COORD_FRAC_BITS{1'b0}}};
    assign w_bhq = {w_cfg.block_height, {COORD_FRAC_BITS{1'b0}}};
    assign w_mdq = {w_cfg.min_distance, {MQW-8{1'b0}}};
    assign w_xr  = 24'(w_cfg.grid_cols) * 24'(w_bwq) + 24'(w_cfg.offset_x);
    assign w_yb  = 24'(w_cfg.grid_rows) * 24'(w_bhq) + 24'(w_cfg.offset_y);

    gfb_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_CHECK && !r_outside),
        .i_num_x(r_dx), .i_num_y(r_dy),
        .i_den_x(20'(w_bwq)), .i_den_y(20'(w_bhq)),
        .o_done(w_div_done), .o_quo_x(w_qx), .o_quo_y(w_qy)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_ocode, r_oidx, r_oacc};

    // block-relative offsets of the point from the block's left and top edges
    assign w_xl = 32'(r_col) * 32'(w_bwq);
    assign w_yt = 32'(r_row) * 32'(w_bhq);
    assign w_ex = 16'(32'(r_dx) - w_xl);
    assign w_ey = 16'(32'(r_dy) - w_yt);

    // both squares can be near 2^32, keep the carry
    assign w_dist = 33'(r_sqx) + 33'(r_sqy);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid && s_axis_tready) n_state = S_CHECK;
            S_CHECK: n_state = r_outside ? S_OUT : S_DIV;
            S_DIV:   if (w_div_done) n_state = S_INDEX;
            S_INDEX: n_state = S_CNT;
            S_CNT:   n_state = (r_idx_full >= 14'(MAX_BLOCKS)) ? S_OUT :
                               (r_kind ? S_EDGE : S_STORE);
            S_EDGE:  n_state = n_done ? S_OUT : S_WALK;
            S_WALK:  n_state = (r_i >= r_cnt) ? S_STORE : S_WAIT;
            S_WAIT:  n_state = S_CMP;
            S_CMP:   n_state = (w_dist <= 33'(r_lim)) ? S_OUT : S_WALK;
            S_STORE: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_done  = 1'b0;
        n_ocode = OUT_STORED;
        if (w_ex < 16'(w_mdq) || 16'(w_bwq) - w_ex < 16'(w_mdq) ||
            w_ey < 16'(w_mdq) || 16'(w_bhq) - w_ey < 16'(w_mdq)) begin
            n_done = 1'b1;
            n_ocode = OUT_EDGE;
        end else if (!(12'(r_cnt) * 12'd4 < 12'(w_cfg.max_per_block) * 12'd3)) begin
            n_done = 1'b1;
            n_ocode = OUT_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cvalid <= '0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser[1]) r_cvalid <= '0;
            if (r_state == S_STORE && r_cnt < CW'(SLOTS_PER_BLOCK)) r_cvalid[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // capture only on the input transaction; a waiting result stays intact
                if (s_axis_tvalid && s_axis_tready) begin
                    r_kind <= s_axis_tuser[0];
                    r_px   <= s_axis_tdata[15:0];
                    r_py   <= s_axis_tdata[31:16];
                    r_oacc <= 1'b0;
                    r_oidx <= 6'd0;
                    r_ocode <= OUT_OUTSIDE;
                    r_outside <= (s_axis_tdata[15:0] <= w_cfg.offset_x) ||
                        (s_axis_tdata[31:16] <= w_cfg.offset_y) ||
                        (24'(s_axis_tdata[15:0]) >= w_xr) ||
                        (24'(s_axis_tdata[31:16]) >= w_yb) ||
                        (w_cfg.block_width == 12'd0) || (w_cfg.block_height == 12'd0) ||
                        (w_cfg.grid_cols == 7'd0) || (w_cfg.grid_rows == 7'd0);
                    r_dx <= s_axis_tdata[15:0] - w_cfg.offset_x;
                    r_dy <= s_axis_tdata[31:16] - w_cfg.offset_y;
                end
            end
            S_INDEX: begin
                r_col <= w_qx;
                r_row <= w_qy;
                r_idx_full <= 14'(w_qy[6:0]) * 14'(w_cfg.grid_cols) + 14'(w_qx[6:0]);
            end
            S_CNT: begin
                r_idx <= r_idx_full[BW-1:0];
                r_cnt <= r_cvalid[r_idx_full[BW-1:0]] ? r_count_mem[r_idx_full[BW-1:0]] : '0;
                r_i   <= '0;
                r_lim <= 32'(w_mdq) * 32'(w_mdq);
                r_oidx <= 6'(r_idx_full);
            end
            S_EDGE: if (n_done) r_ocode <= n_ocode;
            S_WAIT: begin
                r_sqx <= 32'(r_px > r_rd[31:16] ? r_px - r_rd[31:16] : r_rd[31:16] - r_px)
                       * 32'(r_px > r_rd[31:16] ? r_px - r_rd[31:16] : r_rd[31:16] - r_px);
                r_sqy <= 32'(r_py > r_rd[15:0] ? r_py - r_rd[15:0] : r_rd[15:0] - r_py)
                       * 32'(r_py > r_rd[15:0] ? r_py - r_rd[15:0] : r_rd[15:0] - r_py);
            end
            S_CMP: if (w_dist <= 33'(r_lim)) r_ocode <= OUT_CLOSE;
            S_STORE: begin
                if (r_cnt >= CW'(SLOTS_PER_BLOCK)) begin
                    r_ocode <= OUT_OVERFLOW;
                end else begin
                    r_ocode <= OUT_STORED;
                    r_oacc  <= 1'b1;
                    r_count_mem[r_idx] <= r_cnt + CW'(1);
                    r_pmem[{r_idx, r_cnt[SW-1:0]}] <= {r_px, r_py};
                end
            end
            default: ;
        endcase
        if (r_state == S_CNT && r_idx_full >= 14'(MAX_BLOCKS)) r_oidx <= 6'd0;
        if (r_state == S_WALK) begin
            r_rd <= r_pmem[AW'({r_idx, r_i[SW-1:0]})];
            r_i  <= r_i + CW'(1);
        end
    end
endmodule

>>> design/gfb_cfg_regs.sv
// Configuration register file of the grid bucketing filter.
module gfb_cfg_regs import gfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;
    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x      <= 16'd0;
            r_cfg.offset_y      <= 16'd0;
            r_cfg.block_width   <= 12'd150;
            r_cfg.block_height  <= 12'd120;
            r_cfg.grid_cols     <= 7'd5;
            r_cfg.grid_rows     <= 7'd4;
            r_cfg.min_distance  <= 8'd15;
            r_cfg.max_per_block <= 10'd20;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OFFSET_X: r_cfg.offset_x      <= i_cfg_data;
                REG_OFFSET_Y: r_cfg.offset_y      <= i_cfg_data;
                REG_BLOCK_W:  r_cfg.block_width   <= i_cfg_data[11:0];
                REG_BLOCK_H:  r_cfg.block_height  <= i_cfg_data[11:0];
                REG_COLS:     r_cfg.grid_cols     <= i_cfg_data[6:0];
                REG_ROWS:     r_cfg.grid_rows     <= i_cfg_data[6:0];
                REG_MIN_DIST: r_cfg.min_distance  <= i_cfg_data[7:0];
                REG_MAX_PB:   r_cfg.max_per_block <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end
endmodule

>>> design/gfb_divider.sv
// Restoring divider producing block column and row one bit a cycle.
module gfb_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num_x,
    input  logic [15:0] i_num_y,
    input  logic [19:0] i_den_x,
    input  logic [19:0] i_den_y,
    output logic        o_done,
    output logic [15:0] o_quo_x,
    output logic [15:0] o_quo_y
);
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [15:0] r_qx, r_qy;
    logic [20:0] r_rx, r_ry;
    logic [20:0] w_tx, w_ty;

    assign w_tx = {r_rx[19:0], r_qx[15]};
    assign w_ty = {r_ry[19:0], r_qy[15]};
    assign o_done = r_busy && (r_cnt == 5'd0);
    assign o_quo_x = r_qx;
    assign o_quo_y = r_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd16;
        end else if (r_busy) begin
            if (r_cnt == 5'd0) r_busy <= 1'b0;
            else r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_qx <= i_num_x;
            r_qy <= i_num_y;
            r_rx <= 21'd0;
            r_ry <= 21'd0;
        end else if (r_busy && r_cnt != 5'd0) begin
            if (w_tx >= {1'b0, i_den_x}) begin
                r_rx <= w_tx - {1'b0, i_den_x};
                r_qx <= {r_qx[14:0], 1'b1};
            end else begin
                r_rx <= w_tx;
                r_qx <= {r_qx[14:0], 1'b0};
            end
            if (w_ty >= {1'b0, i_den_y}) begin
                r_ry <= w_ty - {1'b0, i_den_y};
                r_qy <= {r_qy[14:0], 1'b1};
            end else begin
                r_ry <= w_ty;
                r_qy <= {r_qy[14:0], 1'b0};
            end
        end
    end
endmodule

>>> design/gfb_checker.sv
// Port-level checks of the grid bucketing filter, bound to the top level.
`include "grid_feature_bucketing_filter_defines.svh"
module gfb_checker import gfb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    logic       w_acc;
    logic [5:0] w_idx;
    logic [2:0] w_oc;

    assign w_acc = m_axis_tdata[0];
    assign w_idx = m_axis_tdata[6:1];
    assign w_oc  = m_axis_tdata[9:7];

    `GFB_ASSERT_IMP(a_acc_stored, i_clk, i_rst_n, m_axis_tvalid, w_acc == (w_oc == OUT_STORED))
    `GFB_ASSERT_IMP(a_out_idx0, i_clk, i_rst_n, m_axis_tvalid && w_oc == OUT_OUTSIDE, w_idx == 6'd0)
    `GFB_ASSERT_IMP(a_code, i_clk, i_rst_n, m_axis_tvalid, w_oc <= OUT_OVERFLOW)
    `GFB_ASSERT_NXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind grid_feature_bucketing_filter gfb_checker u_gfb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
